// File: design/particle_to_grid_scatter_assert.svh
// Assertion macros for the particle-to-grid scatter checker.
`ifndef PARTICLE_TO_GRID_SCATTER_ASSERT_SVH
`define PARTICLE_TO_GRID_SCATTER_ASSERT_SVH

// Same-cycle implication.
`define P2G_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define P2G_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/p2g_pkg.sv
// Shared types and constants for the particle-to-grid scatter.
`default_nettype none
package p2g_pkg;

   localparam int NODES_DEFAULT = 4096;
   localparam int DIMS_DEFAULT  = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int VEC_SLOTS     = 6;

   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_SCATTER = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [11:0]        node_index;
      logic [31:0]        particle_mass;
      logic [16:0]        shape_weight;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
   } req_type;

   typedef struct packed {
      logic [47:0]        node_mass;
      logic               mass_positive;
      logic signed [31:0] node_disp_x;
      logic signed [31:0] node_disp_y;
      logic signed [31:0] node_vel_x;
      logic signed [31:0] node_vel_y;
      logic signed [31:0] node_acc_x;
      logic signed [31:0] node_acc_y;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_SCATTER,
      OP_READ,
      OP_READ_ZERO
   } op_type;

   typedef struct packed {
      op_type                          op;
      logic [11:0]                     node;
      logic [31:0]                     mass;
      logic [16:0]                     weight;
      logic [VEC_SLOTS-1:0][31:0]      vec;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SC_C,
      ST_SC_MASS,
      ST_SC_MUL,
      ST_SC_ADD,
      ST_RD_MASS,
      ST_RD_SUM,
      ST_RD_LOAD,
      ST_RD_DIV,
      ST_RD_FIN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// File: design/p2g_front.sv
// Front end: accept, classify and queue items for the execution back end.
`default_nettype none
module p2g_front #(
   parameter int NODES = p2g_pkg::NODES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  p2g_pkg::req_type       req_payload,
   output p2g_pkg::queue_out_type q_out,
   input  logic                   q_stall
);
   import p2g_pkg::*;

   localparam int QPW = $clog2(QUEUE_DEPTH);

   entry_type        q_mem [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]     count_ff, count_in;
   logic             keep;
   logic             in_range;
   logic             push;
   logic             pop;
   entry_type        entry;

   assign in_range = 32'(req_payload.node_index) < NODES;

   always_comb begin
      entry.node   = req_payload.node_index;
      entry.mass   = req_payload.particle_mass;
      entry.weight = req_payload.shape_weight;
      entry.vec    = {req_payload.acc_y, req_payload.acc_x, req_payload.vel_y,
                      req_payload.vel_x, req_payload.disp_y, req_payload.disp_x};
      entry.op     = OP_CLEAR;
      keep         = 1'b0;
      case (req_payload.func)
         FUNC_CLEAR: begin
            entry.op = OP_CLEAR;
            keep     = in_range;
         end
         FUNC_SCATTER: begin
            entry.op = OP_SCATTER;
            keep     = in_range && (req_payload.shape_weight != 17'd0);
         end
         FUNC_READ: begin
            entry.op = in_range ? OP_READ : OP_READ_ZERO;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall   = count_ff == (QPW+1)'(QUEUE_DEPTH);
   assign push        = req_valid && !req_stall && keep;
   assign q_out.valid = count_ff != '0;
   assign q_out.entry = q_mem[rd_ptr_ff];
   assign pop         = q_out.valid && !q_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

// File: design/p2g_back.sv
// Back end: node stores, scatter accumulation, normalizing divider, result register.
`default_nettype none
module p2g_back #(
   parameter int NODES = p2g_pkg::NODES_DEFAULT,
   parameter int DIMS  = p2g_pkg::DIMS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  p2g_pkg::queue_out_type q_out,
   output logic                   q_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output p2g_pkg::rsp_type       rsp_payload
);
   import p2g_pkg::*;

   localparam int COMPS = 3 * DIMS;
   localparam int AW    = $clog2(NODES);
   localparam int SAW   = $clog2(NODES * COMPS);
   localparam int KW    = $clog2(COMPS);

   logic [47:0] mass_mem [NODES];
   logic [47:0] sum_mem  [NODES * COMPS];

   state_type   state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   entry_type   item_ff;
   logic [32:0] c_ff;
   logic [64:0] prod_ff;
   logic [47:0] mass_rd_ff;
   logic [47:0] sum_rd_ff;
   logic [47:0] m_ff;
   logic [63:0] quo_ff;
   logic [48:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [31:0] res_ff [VEC_SLOTS];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic            pop;
   logic            k_last;
   logic            m_zero;
   logic            rsp_load;
   logic [2:0]      slot;
   logic [AW-1:0]   node_addr;
   logic [SAW-1:0]  sum_raddr;
   logic [SAW-1:0]  sum_waddr;
   logic            mass_we;
   logic [47:0]     mass_wdata;
   logic            sum_we;
   logic [47:0]     sum_wdata;
   logic [48:0]     mw;
   logic [48:0]     mass_sum;
   logic [47:0]     mass_sat;
   logic [31:0]     v;
   logic            vneg;
   logic [31:0]     vmag;
   logic [49:0]     acc;
   logic [47:0]     acc_sat;
   logic            sneg;
   logic [47:0]     smag;
   logic [31:0]     raw_sat;
   logic [49:0]     trial;
   logic [48:0]     shifted;
   logic            ge;
   logic [31:0]     q_sat;

   assign pop      = q_out.valid && (state_ff == ST_IDLE);
   assign q_stall  = state_ff != ST_IDLE;
   assign k_last   = k_ff == KW'(COMPS - 1);
   assign m_zero   = m_ff == '0;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign slot     = (DIMS == 2) ? 3'(k_ff) : (3'(k_ff) << 1);
   assign node_addr = AW'(item_ff.node);
   assign sum_raddr = SAW'(32'(node_addr) * COMPS + 32'(k_in));
   assign sum_waddr = SAW'(32'(node_addr) * COMPS + 32'(k_ff));

   assign mw       = 49'(item_ff.mass) * 49'(item_ff.weight);
   assign mass_sum = {1'b0, mass_rd_ff} + 49'(c_ff);
   assign mass_sat = mass_sum[48] ? '1 : mass_sum[47:0];

   assign v    = item_ff.vec[slot];
   assign vneg = v[31];
   assign vmag = vneg ? (~v + 32'd1) : v;

   assign acc     = neg_ff ? ({{2{sum_rd_ff[47]}}, sum_rd_ff} - {2'b00, prod_ff[63:16]})
                           : ({{2{sum_rd_ff[47]}}, sum_rd_ff} + {2'b00, prod_ff[63:16]});
   assign acc_sat = (acc[49:47] == 3'b000 || acc[49:47] == 3'b111) ? acc[47:0]
                  : (acc[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

   assign sneg    = sum_rd_ff[47];
   assign smag    = sneg ? (~sum_rd_ff + 48'd1) : sum_rd_ff;
   assign raw_sat = (sum_rd_ff[47:31] == '0 || sum_rd_ff[47:31] == '1) ? sum_rd_ff[31:0]
                  : (sneg ? 32'h8000_0000 : 32'h7FFF_FFFF);

   assign shifted = {rem_ff[47:0], quo_ff[63]};
   assign trial   = {1'b0, shifted} - {2'b00, m_ff};
   assign ge      = !trial[49];

   always_comb begin
      if (neg_ff) begin
         q_sat = (quo_ff > 64'h8000_0000) ? 32'h8000_0000 : (~quo_ff[31:0] + 32'd1);
      end else begin
         q_sat = (quo_ff[63:31] != '0) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (q_out.entry.op)
                  OP_CLEAR:   state_in = ST_CLEAR;
                  OP_SCATTER: state_in = ST_SC_C;
                  OP_READ:    state_in = ST_RD_MASS;
                  default:    state_in = ST_OUT;
               endcase
            end
         end
         ST_CLEAR:   state_in = k_last ? ST_IDLE : ST_CLEAR;
         ST_SC_C:    state_in = ST_SC_MASS;
         ST_SC_MASS: state_in = ST_SC_MUL;
         ST_SC_MUL:  state_in = ST_SC_ADD;
         ST_SC_ADD:  state_in = k_last ? ST_IDLE : ST_SC_MUL;
         ST_RD_MASS: state_in = ST_RD_SUM;
         ST_RD_SUM:  state_in = ST_RD_LOAD;
         ST_RD_LOAD: state_in = m_zero ? (k_last ? ST_OUT : ST_RD_LOAD) : ST_RD_DIV;
         ST_RD_DIV:  state_in = (cnt_ff == '1) ? ST_RD_FIN : ST_RD_DIV;
         ST_RD_FIN:  state_in = k_last ? ST_OUT : ST_RD_LOAD;
         ST_OUT:     state_in = rsp_load ? ST_IDLE : ST_OUT;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      k_in       = k_ff;
      mass_we    = 1'b0;
      mass_wdata = mass_sat;
      sum_we     = 1'b0;
      sum_wdata  = acc_sat;
      case (state_ff)
         ST_IDLE: begin
            k_in = '0;
         end
         ST_CLEAR: begin
            mass_we    = k_ff == '0;
            mass_wdata = '0;
            sum_we     = 1'b1;
            sum_wdata  = '0;
            k_in       = k_last ? k_ff : k_ff + 1'b1;
         end
         ST_SC_MASS: begin
            mass_we = 1'b1;
         end
         ST_SC_ADD: begin
            sum_we = 1'b1;
            k_in   = k_last ? k_ff : k_ff + 1'b1;
         end
         ST_RD_LOAD: begin
            if (m_zero && !k_last) begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_RD_FIN: begin
            k_in = k_last ? k_ff : k_ff + 1'b1;
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mass_we) begin
         mass_mem[node_addr] <= mass_wdata;
      end
      mass_rd_ff <= mass_mem[node_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               item_ff <= q_out.entry;
               m_ff    <= '0;
               for (int i = 0; i < VEC_SLOTS; i++) begin
                  res_ff[i] <= '0;
               end
            end
         end
         ST_SC_C: begin
            c_ff <= mw[48:16];
         end
         ST_SC_MUL: begin
            prod_ff <= 65'(c_ff) * 65'(vmag);
            neg_ff  <= vneg;
         end
         ST_RD_SUM: begin
            m_ff <= mass_rd_ff;
         end
         ST_RD_LOAD: begin
            if (m_zero) begin
               res_ff[slot] <= raw_sat;
            end else begin
               rem_ff <= '0;
               quo_ff <= {smag, 16'd0};
               neg_ff <= sneg;
               cnt_ff <= '0;
            end
         end
         ST_RD_DIV: begin
            rem_ff <= ge ? trial[48:0] : shifted;
            quo_ff <= {quo_ff[62:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_RD_FIN: begin
            res_ff[slot] <= q_sat;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_ff.node_mass     <= m_ff;
         rsp_ff.mass_positive <= !m_zero;
         rsp_ff.node_disp_x   <= res_ff[0];
         rsp_ff.node_disp_y   <= res_ff[1];
         rsp_ff.node_vel_x    <= res_ff[2];
         rsp_ff.node_vel_y    <= res_ff[3];
         rsp_ff.node_acc_x    <= res_ff[4];
         rsp_ff.node_acc_y    <= res_ff[5];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// File: design/particle_to_grid_scatter.sv
// Top level of the particle-to-grid scatter.
//
// Items enter on req_valid/req_stall with a req_type payload. Clear items zero a node,
// scatter items add a particle's mass-weighted contribution, read items return one
// rsp_type transfer on rsp_valid/rsp_stall. Other items cause no transfer.
// A two-entry queue sits between the classifying front end and the execution back end,
// so items are taken while the back end works. The back end runs one item at a time
// through node stores (C = 3 * DIMS sum entries per node):
//   clear   zeroes the node mass and its C sum entries, one sum entry a step
//   scatter mass update, then one shared 33x32 multiplier, one store read and write a step
//   read    mass load, then each component is copied (saturated) when the mass is zero,
//           else put through the 64-step bit-serial divider, then into the result register
// req_stall rises only when the queue is full. A result waits in the output register
// while rsp_stall is high; the back end holds the next read until it drains.
// Reset empties the queue and result register; node stores are not cleared and a node
// must be cleared before it is scattered to or read.
`default_nettype none
module particle_to_grid_scatter #(
   parameter int NODES = p2g_pkg::NODES_DEFAULT,
   parameter int DIMS  = p2g_pkg::DIMS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  p2g_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output p2g_pkg::rsp_type rsp_payload
);
   import p2g_pkg::*;

   queue_out_type q_out;
   logic          q_stall;

   p2g_front #(
      .NODES(NODES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .q_out      (q_out),
      .q_stall    (q_stall)
   );

   p2g_back #(
      .NODES(NODES),
      .DIMS (DIMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_stall    (q_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

// File: design/p2g_checker.sv
// Port checker for the particle-to-grid scatter, bound to the top level.
`default_nettype none
`include "particle_to_grid_scatter_assert.svh"
module p2g_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input p2g_pkg::rsp_type rsp_payload
);
   `P2G_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `P2G_ASSERT_IMP(a_mass_flag, clock, reset, rsp_valid, rsp_payload.mass_positive == (rsp_payload.node_mass != 48'd0))
   `P2G_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind particle_to_grid_scatter p2g_checker u_p2g_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
`default_nettype wire

// File: sim/particle_to_grid_scatter_test.sv
// Self-checking testbench for the particle-to-grid scatter: clears, scatters and reads.
`timescale 1ns / 1ps
`default_nettype none
module particle_to_grid_scatter_test;
   import p2g_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int NODE_COUNT = 4096;
   localparam int SLOT_COUNT = 6;
   localparam bit [63:0] MASS_LIMIT = 64'hFFFF_FFFF_FFFF;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -64'sh8000_0000_0000;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 500;

   class node_scoreboard;
      bit [63:0] node_mass_tab[NODE_COUNT];
      longint    sum_tab[NODE_COUNT * SLOT_COUNT];
      rsp_type   pending_reads[$];
      int        errors;

      function automatic longint add_term(longint sum, bit [63:0] c, logic signed [31:0] v);
         bit        neg;
         longint    sv;
         bit [63:0] mag;
         bit [63:0] term;
         longint    s;
         neg = v[31];
         sv = v;
         mag = neg ? -sv : sv;
         term = (c * mag) >> 16;
         s = neg ? sum - longint'(term) : sum + longint'(term);
         if (s > SUM_HI) s = SUM_HI;
         if (s < SUM_LO) s = SUM_LO;
         return s;
      endfunction

      function automatic logic [31:0] average(longint sum, bit [63:0] m);
         bit [63:0] mag;
         bit [63:0] q;
         if (m == 0) begin
            if (sum > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (sum < -64'sd2147483648) return 32'h8000_0000;
            return sum[31:0];
         end
         mag = (sum < 0) ? -sum : sum;
         q = (mag << 16) / m;
         if (sum < 0) begin
            if (q > 64'd2147483648) return 32'h8000_0000;
            return 32'(-q);
         end
         if (q > 64'd2147483647) return 32'h7FFF_FFFF;
         return q[31:0];
      endfunction

      function void note_request(req_type r);
         logic signed [31:0] vec[SLOT_COUNT];
         logic [31:0]        avg[SLOT_COUNT];
         bit [63:0]          c;
         bit [63:0]          nm;
         rsp_type            e;
         int                 n;
         n = r.node_index;
         vec = '{r.disp_x, r.disp_y, r.vel_x, r.vel_y, r.acc_x, r.acc_y};
         case (r.func)
            FUNC_CLEAR: begin
               node_mass_tab[n] = 0;
               for (int k = 0; k < SLOT_COUNT; k++) sum_tab[n * SLOT_COUNT + k] = 0;
            end
            FUNC_SCATTER: begin
               if (r.shape_weight != 0) begin
                  c = (64'(r.particle_mass) * 64'(r.shape_weight)) >> 16;
                  nm = node_mass_tab[n] + c;
                  node_mass_tab[n] = (nm > MASS_LIMIT) ? MASS_LIMIT : nm;
                  for (int k = 0; k < SLOT_COUNT; k++)
                     sum_tab[n * SLOT_COUNT + k] =
                        add_term(sum_tab[n * SLOT_COUNT + k], c, vec[k]);
               end
            end
            FUNC_READ: begin
               for (int k = 0; k < SLOT_COUNT; k++)
                  avg[k] = average(sum_tab[n * SLOT_COUNT + k], node_mass_tab[n]);
               e.node_mass = node_mass_tab[n][47:0];
               e.mass_positive = node_mass_tab[n] != 0;
               e.node_disp_x = avg[0];
               e.node_disp_y = avg[1];
               e.node_vel_x = avg[2];
               e.node_vel_y = avg[3];
               e.node_acc_x = avg[4];
               e.node_acc_y = avg[5];
               pending_reads.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending_reads.size() == 0) begin
            $error("unexpected result transfer %h", a);
            errors++;
            return;
         end
         e = pending_reads.pop_front();
         if (a.node_mass !== e.node_mass) begin
            $error("node_mass expected %h actual %h", e.node_mass, a.node_mass); errors++;
         end
         if (a.mass_positive !== e.mass_positive) begin
            $error("mass_positive expected %b actual %b", e.mass_positive, a.mass_positive);
            errors++;
         end
         if (a.node_disp_x !== e.node_disp_x) begin
            $error("node_disp_x expected %h actual %h", e.node_disp_x, a.node_disp_x); errors++;
         end
         if (a.node_disp_y !== e.node_disp_y) begin
            $error("node_disp_y expected %h actual %h", e.node_disp_y, a.node_disp_y); errors++;
         end
         if (a.node_vel_x !== e.node_vel_x) begin
            $error("node_vel_x expected %h actual %h", e.node_vel_x, a.node_vel_x); errors++;
         end
         if (a.node_vel_y !== e.node_vel_y) begin
            $error("node_vel_y expected %h actual %h", e.node_vel_y, a.node_vel_y); errors++;
         end
         if (a.node_acc_x !== e.node_acc_x) begin
            $error("node_acc_x expected %h actual %h", e.node_acc_x, a.node_acc_x); errors++;
         end
         if (a.node_acc_y !== e.node_acc_y) begin
            $error("node_acc_y expected %h actual %h", e.node_acc_y, a.node_acc_y); errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   node_scoreboard sb = new();
   int  cycles = 0;
   int  hold_left = 0;
   int  sent = 0;
   bit  send_quiet = 1'b0;
   bit  node_live[NODE_COUNT];
   int  live_nodes[$];

   particle_to_grid_scatter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (cycles > 40000 && cycles < 70000) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < 16;
      end
   end

   task automatic send(input req_type r);
      req_payload <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      sent++;
      if (r.func == FUNC_CLEAR && !node_live[r.node_index]) begin
         node_live[r.node_index] = 1'b1;
         live_nodes.push_back(r.node_index);
      end
      if (!send_quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] f, int n);
      req_type r;
      r.func = f;
      r.node_index = 12'(n);
      r.particle_mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000);
      r.shape_weight = $urandom_range(0, 15) == 0 ? 17'd0 : 17'($urandom_range(1, 65536));
      r.disp_x = $urandom_range(0, 1) ? $urandom
               : 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      r.disp_y = $urandom;
      r.vel_x = $urandom;
      r.vel_y = $urandom_range(0, 1) ? $urandom
              : 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
      r.acc_x = $urandom;
      r.acc_y = $urandom;
      return r;
   endfunction

   initial begin
      req_type r;
      int      pick;
      int      n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero mass read, extremes, zero weight, sub-LSB contribution, unused func
      r = make_req(FUNC_CLEAR, 0); send(r);
      r = make_req(FUNC_CLEAR, 4095); send(r);
      r = make_req(FUNC_CLEAR, 12'hAAA); send(r);
      r = make_req(FUNC_READ, 0); send(r);
      r = make_req(FUNC_SCATTER, 0);
      r.particle_mass = '1; r.shape_weight = 17'd65536;
      r.disp_x = 32'sh8000_0000; r.disp_y = 32'sh7FFF_FFFF; r.vel_x = 32'sh8000_0000;
      r.vel_y = 32'sh7FFF_FFFF; r.acc_x = 0; r.acc_y = -1;
      send(r); send(r);
      r = make_req(FUNC_READ, 0); send(r);
      r = make_req(FUNC_SCATTER, 4095); r.shape_weight = 0; send(r);
      r = make_req(FUNC_READ, 4095); send(r);
      r = make_req(FUNC_SCATTER, 4095); r.particle_mass = 1; r.shape_weight = 1; send(r);
      r = make_req(FUNC_READ, 4095); send(r);
      r = make_req(FUNC_SCATTER, 4095); r.particle_mass = 32'h10000;
      r.shape_weight = 17'd65536; r.disp_x = 32'sh8000_0000; send(r);
      r = make_req(FUNC_SCATTER, 4095); r.particle_mass = 32'h30000;
      r.shape_weight = 17'd1; send(r);
      r = make_req(FUNC_READ, 4095); send(r);
      r = make_req(FUNC_UNUSED, 12'h555); send(r);
      r = make_req(FUNC_SCATTER, 12'hAAA); send(r);
      r = make_req(FUNC_READ, 12'hAAA); send(r);
      r = make_req(FUNC_CLEAR, 0); send(r);
      r = make_req(FUNC_READ, 0); send(r);
      drain();

      for (int i = 0; i < 1600; i++) begin
         send_quiet = (i >= 700 && i < 1000);
         if (i == 400) hold_left = 400;
         if (i == 1200) drain();
         pick = $urandom_range(0, 99);
         if (pick < 10 || live_nodes.size() < 4) begin
            n = $urandom_range(0, 1) ? $urandom_range(0, NODE_COUNT - 1)
                                     : live_nodes[$urandom_range(0, live_nodes.size() - 1)];
            r = make_req(FUNC_CLEAR, n);
         end else begin
            n = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
            if (pick < 72) r = make_req(FUNC_SCATTER, n);
            else if (pick < 97) r = make_req(FUNC_READ, n);
            else r = make_req(FUNC_UNUSED, $urandom_range(0, NODE_COUNT - 1));
         end
         send(r);
      end
      drain();

      if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: particle_to_grid_scatter.f
+incdir+design
design/p2g_pkg.sv
design/p2g_front.sv
design/p2g_back.sv
design/particle_to_grid_scatter.sv
design/p2g_checker.sv
sim/particle_to_grid_scatter_test.sv
